### design/aic_pkg.sv
// ----------------------------------------------------------------------------
// Impact classifier package
// Shared types and constants for the accelerometer impact classifier.
// ----------------------------------------------------------------------------
package aic_pkg;

   typedef enum logic [1:0] {
      MOOD_NEUTRAL = 2'd0,
      MOOD_WEAK    = 2'd1,
      MOOD_STRONG  = 2'd2
   } mood_type;

   typedef enum logic [1:0] {
      EVENT_NONE   = 2'd0,
      EVENT_WEAK   = 2'd1,
      EVENT_STRONG = 2'd2,
      EVENT_REVERT = 2'd3
   } event_type;

   typedef enum logic {
      FUNC_SAMPLE = 1'b0,
      FUNC_HOLD   = 1'b1
   } func_type;

   localparam logic [1:0] CSR_STRONG_THR = 2'd0;
   localparam logic [1:0] CSR_WEAK_THR   = 2'd1;
   localparam logic [1:0] CSR_COOLDOWN   = 2'd2;
   localparam logic [1:0] CSR_HOLD       = 2'd3;

   localparam logic [63:0] STRONG_THR_RESET = 64'd133040906960896;
   localparam logic [63:0] WEAK_THR_RESET   = 64'd274877906944;
   localparam logic [15:0] COOLDOWN_RESET   = 16'd300;
   localparam logic [15:0] HOLD_RESET       = 16'd1500;

   typedef struct packed {
      func_type    func;
      logic [31:0] time_ms;
      logic [63:0] diff_sq;
   } aic_item_type;

   typedef struct packed {
      logic         valid;
      aic_item_type item;
   } aic_push_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  index;
      logic [63:0] data;
   } aic_csr_type;

endpackage

### design/aic_front.sv
// ----------------------------------------------------------------------------
// Impact classifier front end
// Accepts transactions, forms the squared magnitude, its change against the
// previous sample and the square of that change, and pushes the result into
// the queue while holding enough queue credit for everything in flight.
// ----------------------------------------------------------------------------
module aic_front #(
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_func,
   input  logic signed [15:0]                 req_accel_x,
   input  logic signed [15:0]                 req_accel_y,
   input  logic signed [15:0]                 req_accel_z,
   input  logic [31:0]                        req_time_ms,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_level,
   output aic_pkg::aic_push_type              push
);
   import aic_pkg::*;

   localparam int unsigned LevelWidth = $clog2(QUEUE_DEPTH + 1);

   logic                   accept;
   logic [1:0]             inflight;
   logic [LevelWidth:0]    occupancy;

   logic signed [31:0]     ext_x;
   logic signed [31:0]     ext_y;
   logic signed [31:0]     ext_z;
   logic signed [31:0]     sq_x;
   logic signed [31:0]     sq_y;
   logic signed [31:0]     sq_z;

   logic                   s1_valid_ff;
   func_type               s1_func_ff;
   logic [31:0]            s1_time_ff;
   logic [31:0]            s1_sqx_ff;
   logic [31:0]            s1_sqy_ff;
   logic [31:0]            s1_sqz_ff;

   logic [31:0]            mag_in;
   logic [31:0]            diff_in;
   logic [31:0]            prev_mag_ff;

   logic                   s2_valid_ff;
   func_type               s2_func_ff;
   logic [31:0]            s2_time_ff;
   logic [31:0]            s2_diff_ff;

   logic [63:0]            diff_sq_in;
   aic_push_type           push_ff;

   assign inflight  = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff} + {1'b0, push_ff.valid};
   assign occupancy = (LevelWidth + 1)'(q_level) + (LevelWidth + 1)'(inflight);
   assign req_stall = occupancy >= (LevelWidth + 1)'(QUEUE_DEPTH);
   assign accept    = req_valid & ~req_stall;

   assign ext_x = 32'(req_accel_x);
   assign ext_y = 32'(req_accel_y);
   assign ext_z = 32'(req_accel_z);
   assign sq_x  = ext_x * ext_x;
   assign sq_y  = ext_y * ext_y;
   assign sq_z  = ext_z * ext_z;

   assign mag_in  = s1_sqx_ff + s1_sqy_ff + s1_sqz_ff;
   assign diff_in = (mag_in >= prev_mag_ff) ? (mag_in - prev_mag_ff) : (prev_mag_ff - mag_in);

   assign diff_sq_in = {32'd0, s2_diff_ff} * {32'd0, s2_diff_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         push_ff.valid <= 1'b0;
         prev_mag_ff   <= '0;
      end else begin
         s1_valid_ff   <= accept;
         s2_valid_ff   <= s1_valid_ff;
         push_ff.valid <= s2_valid_ff;
         if (s1_valid_ff && (s1_func_ff == FUNC_SAMPLE)) begin
            prev_mag_ff <= mag_in;
         end
      end
      s1_func_ff           <= func_type'(req_func);
      s1_time_ff           <= req_time_ms;
      s1_sqx_ff            <= sq_x;
      s1_sqy_ff            <= sq_y;
      s1_sqz_ff            <= sq_z;
      s2_func_ff           <= s1_func_ff;
      s2_time_ff           <= s1_time_ff;
      s2_diff_ff           <= diff_in;
      push_ff.item.func    <= s2_func_ff;
      push_ff.item.time_ms <= s2_time_ff;
      push_ff.item.diff_sq <= diff_sq_in;
   end

   assign push = push_ff;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy <= (LevelWidth + 1)'(QUEUE_DEPTH))
      else $error("front end holds more items than the queue can take");

endmodule

### design/aic_queue.sv
// ----------------------------------------------------------------------------
// Impact classifier queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module aic_queue #(
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  aic_pkg::aic_push_type              push,
   input  logic                               pop,
   output logic                               head_valid,
   output aic_pkg::aic_item_type              head_item,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   level
);
   import aic_pkg::*;

   localparam int unsigned PtrWidth   = $clog2(QUEUE_DEPTH);
   localparam int unsigned LevelWidth = $clog2(QUEUE_DEPTH + 1);

   aic_item_type          entry_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff;
   logic [PtrWidth-1:0]   rd_ptr_ff;
   logic [LevelWidth-1:0] level_ff;

   assign head_valid = level_ff != '0;
   assign head_item  = entry_ff[rd_ptr_ff];
   assign level      = level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push.valid && !pop) begin
            level_ff <= level_ff + 1'b1;
         end else if (!push.valid && pop) begin
            level_ff <= level_ff - 1'b1;
         end
      end
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (level_ff < LevelWidth'(QUEUE_DEPTH)) || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

endmodule

### design/aic_back.sv
// ----------------------------------------------------------------------------
// Impact classifier back end
// Holds the configuration and the mood state, applies the cooldown, threshold
// and hold rules to each queued transaction and registers the result.
// ----------------------------------------------------------------------------
module aic_back (
   input  logic                  clock,
   input  logic                  reset,
   input  aic_pkg::aic_csr_type  csr,
   input  logic                  head_valid,
   input  aic_pkg::aic_item_type head_item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_mood,
   output logic [1:0]            rsp_event_res,
   output logic                  rsp_sound_active
);
   import aic_pkg::*;

   logic [63:0] strong_thr_ff;
   logic [63:0] weak_thr_ff;
   logic [15:0] cooldown_ff;
   logic [15:0] hold_ff;

   mood_type    mood_ff;
   mood_type    mood_in;
   logic        sound_ff;
   logic        sound_in;
   logic [31:0] last_detect_ff;
   logic [31:0] last_detect_in;
   logic [31:0] mood_start_ff;
   logic [31:0] mood_start_in;
   event_type   event_in;

   logic [31:0] since_detect;
   logic [31:0] since_start;

   logic        rsp_valid_ff;
   mood_type    rsp_mood_ff;
   event_type   rsp_event_ff;
   logic        rsp_sound_ff;

   assign pop          = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign since_detect = head_item.time_ms - last_detect_ff;
   assign since_start  = head_item.time_ms - mood_start_ff;

   always_comb begin
      mood_in        = mood_ff;
      sound_in       = sound_ff;
      last_detect_in = last_detect_ff;
      mood_start_in  = mood_start_ff;
      event_in       = EVENT_NONE;
      if (head_item.func == FUNC_HOLD) begin
         if (since_start > {16'd0, hold_ff}) begin
            mood_in  = MOOD_NEUTRAL;
            sound_in = 1'b0;
            event_in = EVENT_REVERT;
         end
      end else if (since_detect > {16'd0, cooldown_ff}) begin
         if (head_item.diff_sq >= strong_thr_ff) begin
            mood_in  = MOOD_STRONG;
            event_in = EVENT_STRONG;
         end else if (head_item.diff_sq >= weak_thr_ff) begin
            mood_in  = MOOD_WEAK;
            event_in = EVENT_WEAK;
         end
         if (event_in != EVENT_NONE) begin
            mood_start_in  = head_item.time_ms;
            last_detect_in = head_item.time_ms;
            sound_in       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strong_thr_ff  <= STRONG_THR_RESET;
         weak_thr_ff    <= WEAK_THR_RESET;
         cooldown_ff    <= COOLDOWN_RESET;
         hold_ff        <= HOLD_RESET;
         mood_ff        <= MOOD_NEUTRAL;
         sound_ff       <= 1'b0;
         last_detect_ff <= '0;
         mood_start_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr.valid) begin
            unique case (csr.index)
               CSR_STRONG_THR: strong_thr_ff <= csr.data;
               CSR_WEAK_THR:   weak_thr_ff   <= csr.data;
               CSR_COOLDOWN:   cooldown_ff   <= csr.data[15:0];
               CSR_HOLD:       hold_ff       <= csr.data[15:0];
               default:        strong_thr_ff <= strong_thr_ff;
            endcase
         end
         if (pop) begin
            mood_ff        <= mood_in;
            sound_ff       <= sound_in;
            last_detect_ff <= last_detect_in;
            mood_start_ff  <= mood_start_in;
            rsp_valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
      if (pop) begin
         rsp_mood_ff  <= mood_in;
         rsp_event_ff <= event_in;
         rsp_sound_ff <= sound_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mood         = rsp_mood_ff;
   assign rsp_event_res    = rsp_event_ff;
   assign rsp_sound_active = rsp_sound_ff;

   a_detect_sets_mood: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_event_ff == EVENT_STRONG || rsp_event_ff == EVENT_WEAK)
      |-> rsp_sound_ff && (rsp_mood_ff == mood_type'(rsp_event_ff)))
      else $error("detection reported without matching mood and sound");

   a_revert_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_event_ff == EVENT_REVERT)
      |-> !rsp_sound_ff && (rsp_mood_ff == MOOD_NEUTRAL))
      else $error("revert reported while mood or sound still set");

endmodule

### design/accel_impact_classifier.sv
// ----------------------------------------------------------------------------
// Accelerometer impact classifier
// Detects weak and strong shocks from three-axis samples and expires the
// resulting mood after a hold time.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle as long as the queue between
// its front end and back end has room: the input stalls once queued entries
// plus the three transactions that can be in the front-end pipeline reach
// QUEUE_DEPTH. Each transaction gives exactly one result. The front end squares
// the axes, forms the change in squared magnitude and squares that change over
// three pipeline stages; the back end applies cooldown, thresholds and hold
// time combinationally and registers the result, so it sustains one result per
// cycle while the result side does not stall.
// Configuration registers are always ready; write them only while the block
// holds no transaction.
module accel_impact_classifier #(
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic [31:0]        req_time_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_mood,
   output logic [1:0]         rsp_event_res,
   output logic               rsp_sound_active,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_wdata
);
   import aic_pkg::*;

   localparam int unsigned LevelWidth = $clog2(QUEUE_DEPTH + 1);

   aic_push_type          push;
   aic_item_type          head_item;
   aic_csr_type           csr;
   logic                  head_valid;
   logic                  pop;
   logic [LevelWidth-1:0] q_level;

   assign csr_ready = 1'b1;
   assign csr.valid = csr_valid;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   aic_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_accel_x (req_accel_x),
      .req_accel_y (req_accel_y),
      .req_accel_z (req_accel_z),
      .req_time_ms (req_time_ms),
      .q_level     (q_level),
      .push        (push)
   );

   aic_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .level      (q_level)
   );

   aic_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr              (csr),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mood         (rsp_mood),
      .rsp_event_res    (rsp_event_res),
      .rsp_sound_active (rsp_sound_active)
   );

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// Impact classifier testbench
// Drives accelerometer samples and hold checks into the classifier under
// several configurations and idle patterns, predicts the mood, event and
// sound flag of every transaction and compares them with the block's results.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import aic_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   typedef struct {
      mood_type  mood;
      event_type ev;
      logic      sound;
   } mood_outcome_type;

   class mood_scoreboard;
      logic [63:0]      strong_thr;
      logic [63:0]      weak_thr;
      logic [15:0]      cooldown_ms;
      logic [15:0]      hold_ms;
      logic [31:0]      prev_mag_sq;
      logic [31:0]      last_detect_ms;
      logic [31:0]      mood_start_ms;
      mood_type         current_mood;
      logic             sound_on;
      mood_outcome_type pending_outcomes[$];
      int               errors;

      function new();
         strong_thr     = STRONG_THR_RESET;
         weak_thr       = WEAK_THR_RESET;
         cooldown_ms    = COOLDOWN_RESET;
         hold_ms        = HOLD_RESET;
         prev_mag_sq    = '0;
         last_detect_ms = '0;
         mood_start_ms  = '0;
         current_mood   = MOOD_NEUTRAL;
         sound_on       = 1'b0;
         errors         = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [63:0] data);
         case (index)
            CSR_STRONG_THR: strong_thr = data;
            CSR_WEAK_THR:   weak_thr = data;
            CSR_COOLDOWN:   cooldown_ms = data[15:0];
            CSR_HOLD:       hold_ms = data[15:0];
         endcase
      endfunction

      function logic [31:0] axis_square(logic signed [15:0] a);
         int v;
         v = a;
         if (v < 0) v = -v;
         return 32'(v * v);
      endfunction

      function void record_item(func_type f, logic signed [15:0] ax, logic signed [15:0] ay,
                                logic signed [15:0] az, logic [31:0] now_ms);
         mood_outcome_type o;
         logic [31:0]      elapsed;
         logic [31:0]      mag;
         logic [63:0]      diff;
         logic [63:0]      diff_sq;
         event_type        ev;
         ev = EVENT_NONE;
         if (f == FUNC_HOLD) begin
            elapsed = now_ms - mood_start_ms;
            if (elapsed > {16'd0, hold_ms}) begin
               current_mood = MOOD_NEUTRAL;
               sound_on = 1'b0;
               ev = EVENT_REVERT;
            end
         end else begin
            mag = axis_square(ax) + axis_square(ay) + axis_square(az);
            diff = (mag >= prev_mag_sq) ? {32'd0, mag - prev_mag_sq}
                                        : {32'd0, prev_mag_sq - mag};
            diff_sq = diff * diff;
            elapsed = now_ms - last_detect_ms;
            if (elapsed > {16'd0, cooldown_ms}) begin
               if (diff_sq >= strong_thr) begin
                  current_mood = MOOD_STRONG;
                  ev = EVENT_STRONG;
               end else if (diff_sq >= weak_thr) begin
                  current_mood = MOOD_WEAK;
                  ev = EVENT_WEAK;
               end
               if (ev != EVENT_NONE) begin
                  mood_start_ms = now_ms;
                  last_detect_ms = now_ms;
                  sound_on = 1'b1;
               end
            end
            prev_mag_sq = mag;
         end
         o.mood = current_mood;
         o.ev = ev;
         o.sound = sound_on;
         pending_outcomes.push_back(o);
      endfunction

      function void check_outcome(logic [1:0] mood, logic [1:0] ev, logic sound);
         mood_outcome_type o;
         if (pending_outcomes.size() == 0) begin
            $error("unexpected result: mood %0d, event_res %0d, sound_active %0d",
                   mood, ev, sound);
            errors++;
            return;
         end
         o = pending_outcomes.pop_front();
         if (mood !== o.mood) begin
            $error("mood mismatch: expected %0d, actual %0d", o.mood, mood);
            errors++;
         end
         if (ev !== o.ev) begin
            $error("event_res mismatch: expected %0d, actual %0d", o.ev, ev);
            errors++;
         end
         if (sound !== o.sound) begin
            $error("sound_active mismatch: expected %0d, actual %0d", o.sound, sound);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_func = 1'b0;
   logic signed [15:0] req_accel_x = '0;
   logic signed [15:0] req_accel_y = '0;
   logic signed [15:0] req_accel_z = '0;
   logic [31:0]        req_time_ms = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_mood;
   logic [1:0]         rsp_event_res;
   logic               rsp_sound_active;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [63:0]        csr_wdata = '0;

   int             idle_pct = 0;
   int             stall_pct = 0;
   int             quiet_cycles = 0;
   mood_scoreboard sb = new();

   accel_impact_classifier dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_accel_x      (req_accel_x),
      .req_accel_y      (req_accel_y),
      .req_accel_z      (req_accel_z),
      .req_time_ms      (req_time_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mood         (rsp_mood),
      .rsp_event_res    (rsp_event_res),
      .rsp_sound_active (rsp_sound_active),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_outcome(rsp_mood, rsp_event_res, rsp_sound_active);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(func_type f, logic signed [15:0] ax, logic signed [15:0] ay,
                            logic signed [15:0] az, logic [31:0] now_ms);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      req_time_ms <= now_ms;
      do @(posedge clock); while (req_stall);
      sb.record_item(f, ax, ay, az, now_ms);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.pending_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic load_config(logic [63:0] thr_strong, logic [63:0] thr_weak,
                              logic [63:0] cooldown, logic [63:0] hold);
      logic [63:0] vals[4];
      logic [1:0]  idx[4];
      vals = '{thr_strong, thr_weak, cooldown, hold};
      idx = '{CSR_STRONG_THR, CSR_WEAK_THR, CSR_COOLDOWN, CSR_HOLD};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(idx[i], vals[i]);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] random_axis();
      case ($urandom_range(9))
         0, 1, 2, 3: return 16'($urandom_range(0, 4095) - 2048);
         4, 5:       return ($urandom_range(1) != 0) ? 16'sd1024 : -16'sd1024;
         6, 7:       return 16'($urandom);
         8:          return -16'sd32768;
         default:    return 16'sd32767;
      endcase
   endfunction

   function automatic logic [63:0] random_threshold();
      logic [63:0] k;
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return {$urandom, $urandom};
         3:       return STRONG_THR_RESET;
         default: begin
            k = 64'($urandom >> $urandom_range(2, 20));
            return k * k;
         end
      endcase
   endfunction

   task automatic random_config();
      logic [63:0] thr_a;
      logic [63:0] thr_b;
      logic [63:0] cooldown;
      logic [63:0] hold;
      thr_a = random_threshold();
      thr_b = random_threshold();
      if ($urandom_range(3) != 0 && thr_a < thr_b) begin
         thr_a = thr_b;
         thr_b = random_threshold() >> $urandom_range(0, 8);
      end
      cooldown = {$urandom, $urandom};
      hold = {$urandom, $urandom};
      case ($urandom_range(5))
         0:       cooldown[15:0] = '0;
         1:       cooldown[15:0] = '1;
         default: cooldown[15:0] = 16'($urandom_range(1, 400));
      endcase
      case ($urandom_range(5))
         0:       hold[15:0] = '0;
         1:       hold[15:0] = '1;
         default: hold[15:0] = 16'($urandom_range(1, 3000));
      endcase
      load_config(thr_a, thr_b, cooldown, hold);
   endtask

   task automatic run_random_phase(int count);
      int          pause_at;
      logic [31:0] now_ms;
      func_type    f;
      pause_at = $urandom_range(50, 150);
      now_ms = $urandom;
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) wait_drain();
         case ($urandom_range(19))
            0:       now_ms += $urandom;
            1, 2:    now_ms += 0;
            default: now_ms += $urandom_range(1, 600);
         endcase
         f = ($urandom_range(3) == 0) ? FUNC_HOLD : FUNC_SAMPLE;
         send_item(f, random_axis(), random_axis(), random_axis(), now_ms);
      end
      wait_drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: cooldown from time zero, wrap of time, hold expiry.
      send_item(FUNC_HOLD, 16'sd0, 16'sd0, 16'sd0, 32'd0);
      send_item(FUNC_SAMPLE, -16'sd32768, -16'sd32768, -16'sd32768, 32'd100);
      send_item(FUNC_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd401);
      send_item(FUNC_SAMPLE, 16'sd1024, 16'sd0, 16'sd0, 32'd500);
      send_item(FUNC_HOLD, 16'sd32767, -16'sd1, 16'sd5, 32'd1000);
      send_item(FUNC_HOLD, 16'sd0, 16'sd0, 16'sd0, 32'd1902);
      send_item(FUNC_HOLD, 16'sd0, 16'sd0, 16'sd0, 32'd1903);
      send_item(FUNC_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd1000);
      send_item(FUNC_SAMPLE, 16'sd1024, 16'sd0, 16'sd0, 32'hFFFF_FF00);
      send_item(FUNC_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0040);
      send_item(FUNC_SAMPLE, 16'sd32767, 16'sd32767, 16'sd32767, 32'd5000);
      wait_drain();

      // Weak limit above strong, difference equal to the strong limit, no cooldown.
      load_config(64'd1 << 40, 64'd1 << 42, 64'd0, 64'd0);
      send_item(FUNC_SAMPLE, 16'sd1024, 16'sd0, 16'sd0, 32'd6000);
      send_item(FUNC_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd6001);
      send_item(FUNC_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd6001);
      send_item(FUNC_HOLD, 16'sd0, 16'sd0, 16'sd0, 32'd6001);
      send_item(FUNC_HOLD, 16'sd0, 16'sd0, 16'sd0, 32'd6002);
      wait_drain();

      load_config('1, '0, 64'hFFFF, 64'hFFFF);
      send_item(FUNC_SAMPLE, 16'sd5, -16'sd5, 16'sd0, 32'd100000);
      send_item(FUNC_HOLD, 16'sd0, 16'sd0, 16'sd0, 32'd100000 + 32'd65535);
      send_item(FUNC_HOLD, 16'sd0, 16'sd0, 16'sd0, 32'd100000 + 32'd65536);
      wait_drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 52; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 31; stall_pct = 31; end
         endcase
         random_config();
         run_random_phase(210);
      end

      stall_pct = 0;
      wait_drain();
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
